// ===== hw/rtl/dlpe_pkg.sv =====
`timescale 1ns / 1ps
package dlpe_pkg;

	// line program header choices
	localparam int DELTA_MIN     = -5;
	localparam int DELTA_SPAN    = 14;
	localparam int SPECIAL_FIRST = 13;
	localparam int MAX_SPECIAL   = 255;
	localparam int ADV_MAX       = (MAX_SPECIAL - SPECIAL_FIRST) / DELTA_SPAN;

	// input item modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_ROW   = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;

	// standard and extended opcodes
	localparam logic [7:0] OP_EXTENDED      = 8'h00;
	localparam logic [7:0] OP_COPY          = 8'h01;
	localparam logic [7:0] OP_ADV_PC        = 8'h02;
	localparam logic [7:0] OP_ADV_LINE      = 8'h03;
	localparam logic [7:0] OP_SET_FILE      = 8'h04;
	localparam logic [7:0] XOP_END_SEQ      = 8'h01;
	localparam logic [7:0] XOP_SET_ADDR     = 8'h02;
	localparam logic [7:0] SET_ADDRESS_LEN  = 8'h09;
	localparam logic [7:0] END_SEQUENCE_LEN = 8'h01;

	// bytes per start and end item
	localparam int START_BYTES = 11;
	localparam int END_BYTES   = 3;

	// reset value of file and line
	localparam logic [15:0] FILE_INIT = 16'd1;
	localparam logic [30:0] LINE_INIT = 31'd1;

	typedef enum logic [1:0] {
		K_START,
		K_ROW,
		K_END
	} kind_t;

	// one classified command from the front to the back
	typedef struct packed {
		kind_t              kind;
		logic               file_chg;
		logic [15:0]        file;
		logic [63:0]        adv;
		logic signed [31:0] delta;
	} cmd_t;

endpackage

// ===== hw/rtl/dwarf_line_program_encoder.sv =====
`timescale 1ns / 1ps
// Line-table row to DWARF4 line-program byte encoder.
// Input channel: in_valid / in_stall with mode, row_address, row_file and
// row_line; a transfer happens when in_valid is high and in_stall is low.
// Mode 0 starts a sequence (set_address 0, 11 bytes), mode 1 encodes a row,
// mode 2 ends the sequence (3 bytes); mode 3 is taken and produces nothing.
// Output channel: out_valid / out_stall with out_byte and last_byte, one byte
// per transfer; last_byte marks the final byte of each input item.
// The front end tracks address, file and line and classifies each item into a
// small command queue; the back end sequences the bytes out one per cycle
// while the output is not stalled, after a load step in the idle state.
// It takes a new item from the queue only once the last one is finished.
// Each item passes the queue entry, sequencer state and output register.
// A stalled output holds its byte; the queue then fills and in_stall rises.
// Reset clears the queue and sequencer and sets address 0, file 1, line 1.
module dwarf_line_program_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] row_address,
	input  logic [15:0] row_file,
	input  logic [30:0] row_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte
);
	import dlpe_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// item intake and classification
	dlpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.row_address (row_address),
		.row_file    (row_file),
		.row_line    (row_line),
		.q_full      (full),
		.q_push      (push),
		.q_cmd       (push_cmd)
	);

	// command queue between the two halves
	dlpe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head_cmd)
	);

	// byte sequencer
	dlpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_head    (head_cmd),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

// ===== hw/rtl/dlpe_front.sv =====
`timescale 1ns / 1ps
module dlpe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    mode,
	input  logic [63:0]   row_address,
	input  logic [15:0]   row_file,
	input  logic [30:0]   row_line,
	input  logic          q_full,
	output logic          q_push,
	output dlpe_pkg::cmd_t q_cmd
);
	import dlpe_pkg::*;

	logic [63:0] cur_addr_q;
	logic [15:0] cur_file_q;
	logic [30:0] cur_line_q;
	logic        accept;

	// input transfer whenever the queue has room; unused mode is dropped
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// classify the item against the tracked state
	always_comb begin
		q_cmd          = '0;
		q_push         = 1'b0;
		q_cmd.file     = row_file;
		q_cmd.file_chg = (row_file != cur_file_q);
		q_cmd.adv      = row_address - cur_addr_q;
		q_cmd.delta    = $signed({1'b0, row_line}) - $signed({1'b0, cur_line_q});
		case (mode)
			MODE_START: begin
				q_cmd.kind = K_START;
				q_push     = accept;
			end
			MODE_ROW: begin
				q_cmd.kind = K_ROW;
				q_push     = accept;
			end
			MODE_END: begin
				q_cmd.kind = K_END;
				q_push     = accept;
			end
			default: begin
				q_cmd.kind = K_END;
				q_push     = 1'b0;
			end
		endcase
	end

	// tracked address, file and line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= '0;
			cur_file_q <= FILE_INIT;
			cur_line_q <= LINE_INIT;
		end else if (accept) begin
			if (mode == MODE_START) begin
				cur_addr_q <= '0;
				cur_file_q <= FILE_INIT;
				cur_line_q <= LINE_INIT;
			end else if (mode == MODE_ROW) begin
				cur_addr_q <= row_address;
				cur_file_q <= row_file;
				cur_line_q <= row_line;
			end
		end
	end

`ifndef SYNTH
	a_start_resets_file: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_START) |=> (cur_file_q == FILE_INIT && cur_addr_q == '0))
		else $error("start did not reset tracked state");
	a_push_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (in_valid && !q_full))
		else $error("queue push without an input transfer");
	a_row_updates_line: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_ROW) |=> cur_line_q == $past(row_line))
		else $error("row did not update tracked line");
`endif

endmodule

// ===== hw/rtl/dlpe_fifo.sv =====
`timescale 1ns / 1ps
module dlpe_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dlpe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output dlpe_pkg::cmd_t head
);
	import dlpe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");
	a_count_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("fill count did not drop on pop");
`endif

endmodule

// ===== hw/rtl/dlpe_back.sv =====
`timescale 1ns / 1ps
module dlpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dlpe_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           last_byte
);
	import dlpe_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE,
		B_START,
		B_END,
		B_FILE_OP,
		B_FILE_ARG,
		B_SPECIAL,
		B_ADV_OP,
		B_ADV_ARG,
		B_LINE_OP,
		B_LINE_ARG,
		B_COPY
	} bstate_t;

	bstate_t            state_q;
	logic [3:0]         cnt_q;
	logic [63:0]        val_q;
	logic [15:0]        file_q;
	logic [63:0]        adv_q;
	logic signed [31:0] delta_q;
	logic [7:0]         sp_q;
	logic               special_q;
	logic               adv_nz_q;
	logic               d_nz_q;
	logic [7:0]         obyte_q;
	logic               olast_q;
	logic               ovalid_q;

	logic               can_emit;
	logic               emit;
	logic               emit_last;
	logic               h_special;
	logic [8:0]         h_sp;
	logic               h_adv_nz;
	logic               h_d_nz;
	logic               uleb_more;
	logic [63:0]        sleb_rest;
	logic               sleb_done;

	// opcode that follows the file change of a row
	function automatic bstate_t row_next(input logic special, input logic adv_nz,
		input logic d_nz);
		bstate_t s;
		if (special) begin
			s = B_SPECIAL;
		end else if (adv_nz) begin
			s = B_ADV_OP;
		end else if (d_nz) begin
			s = B_LINE_OP;
		end else begin
			s = B_COPY;
		end
		return s;
	endfunction

	// special opcode check on the queue head
	always_comb begin
		h_adv_nz  = |q_head.adv;
		h_d_nz    = |q_head.delta;
		h_sp      = 9'(q_head.delta) + 9'(-DELTA_MIN)
			+ 9'(q_head.adv[4:0]) * 9'(DELTA_SPAN) + 9'(SPECIAL_FIRST);
		h_special = (q_head.adv <= 64'(ADV_MAX))
			&& (q_head.delta >= $signed(32'(DELTA_MIN)))
			&& (q_head.delta < $signed(32'(DELTA_SPAN + DELTA_MIN)))
			&& (h_sp <= 9'(MAX_SPECIAL));
	end

	// leb128 digit logic
	assign uleb_more = |val_q[63:7];
	assign sleb_rest = $signed(val_q) >>> 7;
	assign sleb_done = ((sleb_rest == '0) && !val_q[6]) || ((&sleb_rest) && val_q[6]);

	assign can_emit = !ovalid_q || !out_stall;
	assign emit     = (state_q != B_IDLE) && can_emit;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;

	// final byte of the item
	assign emit_last = (state_q == B_SPECIAL) || (state_q == B_COPY)
		|| ((state_q == B_START) && (cnt_q == 4'(START_BYTES - 1)))
		|| ((state_q == B_END) && (cnt_q == 4'(END_BYTES - 1)));

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign last_byte = olast_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			val_q     <= '0;
			file_q    <= '0;
			adv_q     <= '0;
			delta_q   <= '0;
			sp_q      <= '0;
			special_q <= 1'b0;
			adv_nz_q  <= 1'b0;
			d_nz_q    <= 1'b0;
			obyte_q   <= '0;
			olast_q   <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
				olast_q  <= emit_last;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						file_q    <= q_head.file;
						adv_q     <= q_head.adv;
						delta_q   <= q_head.delta;
						sp_q      <= h_sp[7:0];
						special_q <= h_special;
						adv_nz_q  <= h_adv_nz;
						d_nz_q    <= h_d_nz;
						cnt_q     <= '0;
						case (q_head.kind)
							K_START: state_q <= B_START;
							K_END:   state_q <= B_END;
							K_ROW: begin
								if (q_head.file_chg) begin
									state_q <= B_FILE_OP;
								end else begin
									state_q <= row_next(h_special, h_adv_nz, h_d_nz);
								end
							end
							default: state_q <= B_IDLE;
						endcase
					end
				end
				B_START: begin
					if (can_emit) begin
						if (cnt_q == 4'd1) begin
							obyte_q <= SET_ADDRESS_LEN;
						end else if (cnt_q == 4'd2) begin
							obyte_q <= XOP_SET_ADDR;
						end else begin
							obyte_q <= OP_EXTENDED;
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 4'(START_BYTES - 1)) begin
							state_q <= B_IDLE;
						end
					end
				end
				B_END: begin
					if (can_emit) begin
						if (cnt_q == 4'd1) begin
							obyte_q <= END_SEQUENCE_LEN;
						end else if (cnt_q == 4'd2) begin
							obyte_q <= XOP_END_SEQ;
						end else begin
							obyte_q <= OP_EXTENDED;
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 4'(END_BYTES - 1)) begin
							state_q <= B_IDLE;
						end
					end
				end
				B_FILE_OP: begin
					if (can_emit) begin
						obyte_q <= OP_SET_FILE;
						val_q   <= 64'(file_q);
						state_q <= B_FILE_ARG;
					end
				end
				B_FILE_ARG: begin
					if (can_emit) begin
						obyte_q <= {uleb_more, val_q[6:0]};
						val_q   <= val_q >> 7;
						if (!uleb_more) begin
							state_q <= row_next(special_q, adv_nz_q, d_nz_q);
						end
					end
				end
				B_SPECIAL: begin
					if (can_emit) begin
						obyte_q <= sp_q;
						state_q <= B_IDLE;
					end
				end
				B_ADV_OP: begin
					if (can_emit) begin
						obyte_q <= OP_ADV_PC;
						val_q   <= adv_q;
						state_q <= B_ADV_ARG;
					end
				end
				B_ADV_ARG: begin
					if (can_emit) begin
						obyte_q <= {uleb_more, val_q[6:0]};
						val_q   <= val_q >> 7;
						if (!uleb_more) begin
							state_q <= d_nz_q ? B_LINE_OP : B_COPY;
						end
					end
				end
				B_LINE_OP: begin
					if (can_emit) begin
						obyte_q <= OP_ADV_LINE;
						val_q   <= 64'(delta_q);
						state_q <= B_LINE_ARG;
					end
				end
				B_LINE_ARG: begin
					if (can_emit) begin
						obyte_q <= {!sleb_done, val_q[6:0]};
						val_q   <= sleb_rest;
						if (sleb_done) begin
							state_q <= B_COPY;
						end
					end
				end
				B_COPY: begin
					if (can_emit) begin
						obyte_q <= OP_COPY;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (state_q == B_SPECIAL || state_q == B_COPY)) |=> (olast_q && state_q == B_IDLE))
		else $error("final byte of a row did not end the item");
	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != B_IDLE)
		else $error("queue entry taken but sequencer idle");
	a_start_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_START) |-> cnt_q < 4'(START_BYTES))
		else $error("start byte count out of range");
`endif

endmodule
